// File: hdl/kcl_pkg.sv
// kcl_pkg: shared types and constants for the keypad code lock
// request and response structs, mode and result codes, code reset values
// no dependencies
package kcl_pkg;

  // digit and code geometry
  localparam int DIGIT_W         = 3;
  localparam int NUM_CODE_REGS   = 4;
  localparam int CODE_LENGTH_DEF = 4;
  localparam int CFG_IDX_W       = 2;
  localparam int HELD_W          = 2;
  localparam int BLINK_CNT_W     = 2;

  // reset value of the code registers, first digit at index 0
  localparam logic [NUM_CODE_REGS-1:0][DIGIT_W-1:0] CODE_RESET =
    {3'd4, 3'd1, 3'd2, 3'd3};

  // blink stops once the light has gone low this many times
  localparam logic [BLINK_CNT_W-1:0] BLINK_LAST = 2'd3;

  // item kinds
  typedef enum logic [1:0] {
    MODE_KEY    = 2'd0,
    MODE_REMOTE = 2'd1,
    MODE_POLL   = 2'd2,
    MODE_BLINK  = 2'd3
  } mode_e;

  // outcome of a code entry
  typedef enum logic [1:0] {
    RES_NONE   = 2'd0,
    RES_ACCEPT = 2'd1,
    RES_REJECT = 2'd2
  } entry_result_e;

  // input request
  typedef struct packed {
    mode_e              mode;
    logic [DIGIT_W-1:0] key_digit;
    logic               remote_bit;
    logic               button_level;
  } in_req_t;

  // output response
  typedef struct packed {
    logic              is_locked;
    logic              error_light;
    entry_result_e     entry_result;
    logic [HELD_W-1:0] digits_held;
  } out_rsp_t;

endpackage

// File: hdl/kcl_code_regs.sv
// kcl_code_regs: configuration registers that hold the unlock code
// uses kcl_pkg; positions past the last register read as zero
module kcl_code_regs #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         cfg_we_i,
  input  logic [kcl_pkg::CFG_IDX_W-1:0]                cfg_idx_i,
  input  logic [kcl_pkg::DIGIT_W-1:0]                  cfg_data_i,
  output logic [CODE_LENGTH-1:0][kcl_pkg::DIGIT_W-1:0] code_o
);

  for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_pos
    if (i < kcl_pkg::NUM_CODE_REGS) begin : g_reg
      logic [kcl_pkg::DIGIT_W-1:0] digit_q;

      // one code digit, written by index
      always_ff @(posedge clk_i or negedge rst_ni) begin
        if (!rst_ni) begin
          digit_q <= kcl_pkg::CODE_RESET[i];
        end else if (cfg_we_i && (cfg_idx_i == kcl_pkg::CFG_IDX_W'(i))) begin
          digit_q <= cfg_data_i;
        end
      end

      assign code_o[i] = digit_q;
    end else begin : g_zero
      // no register behind this position
      assign code_o[i] = '0;
    end
  end

endmodule

// File: hdl/kcl_lock_core.sv
// kcl_lock_core: lock state, digit store, blink control and result logic
// uses kcl_pkg; one request is applied per fire_i pulse
module kcl_lock_core #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  logic                                         clk_i,
  input  logic                                         rst_ni,
  input  logic                                         fire_i,
  input  kcl_pkg::in_req_t                             req_i,
  input  logic [CODE_LENGTH-1:0][kcl_pkg::DIGIT_W-1:0] code_i,
  output kcl_pkg::out_rsp_t                            rsp_o
);

  localparam int CNT_W = (CODE_LENGTH > 1) ? $clog2(CODE_LENGTH) : 1;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(CODE_LENGTH - 1);

  logic [CODE_LENGTH-1:0][kcl_pkg::DIGIT_W-1:0] entered_q;
  logic [CODE_LENGTH-1:0]                       pos_ok;
  logic [CNT_W-1:0]                             count_q, count_d;
  logic                                         locked_q, locked_d;
  logic                                         prev_btn_q, prev_btn_d;
  logic                                         blink_q, blink_d;
  logic [kcl_pkg::BLINK_CNT_W-1:0]              blink_cnt_q, blink_cnt_d, blink_inc;
  logic                                         err_q, err_d;
  logic                                         key_fire, code_done, code_match;
  kcl_pkg::entry_result_e                       result;

  assign key_fire  = fire_i && (req_i.mode == kcl_pkg::MODE_KEY);
  assign code_done = (count_q == CNT_LAST);

  // digit store and per-position compare, last position taken from the key
  for (genvar i = 0; i < CODE_LENGTH; i++) begin : g_digit
    always_ff @(posedge clk_i) begin
      if (key_fire && (count_q == CNT_W'(i))) begin
        entered_q[i] <= req_i.key_digit;
      end
    end

    if (i == CODE_LENGTH - 1) begin : g_last
      assign pos_ok[i] = (req_i.key_digit == code_i[i]);
    end else begin : g_held
      assign pos_ok[i] = (entered_q[i] == code_i[i]);
    end
  end

  assign code_match = &pos_ok;
  assign blink_inc  = blink_cnt_q + kcl_pkg::BLINK_CNT_W'(1);

  // next state and result
  always_comb begin
    count_d     = count_q;
    locked_d    = locked_q;
    prev_btn_d  = prev_btn_q;
    blink_d     = blink_q;
    blink_cnt_d = blink_cnt_q;
    err_d       = err_q;
    result      = kcl_pkg::RES_NONE;
    case (req_i.mode)
      kcl_pkg::MODE_KEY: begin
        if (code_done) begin
          count_d = '0;
          if (code_match) begin
            result   = kcl_pkg::RES_ACCEPT;
            locked_d = 1'b0;
          end else begin
            result      = kcl_pkg::RES_REJECT;
            blink_d     = 1'b1;
            blink_cnt_d = '0;
          end
        end else begin
          count_d = count_q + CNT_W'(1);
        end
      end
      kcl_pkg::MODE_REMOTE: begin
        if (req_i.remote_bit) begin
          locked_d = 1'b0;
        end
      end
      kcl_pkg::MODE_POLL: begin
        if (req_i.button_level && prev_btn_q) begin
          locked_d = 1'b1;
        end
        prev_btn_d = req_i.button_level;
      end
      kcl_pkg::MODE_BLINK: begin
        if (blink_q) begin
          err_d = !err_q;
          // count a low transition, stop after the last one
          if (err_q) begin
            if (blink_inc == kcl_pkg::BLINK_LAST) begin
              blink_cnt_d = '0;
              blink_d     = 1'b0;
            end else begin
              blink_cnt_d = blink_inc;
            end
          end
        end
      end
      default: begin
        result = kcl_pkg::RES_NONE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      locked_q    <= 1'b1;
      prev_btn_q  <= 1'b0;
      blink_q     <= 1'b0;
      blink_cnt_q <= '0;
      err_q       <= 1'b0;
    end else if (fire_i) begin
      count_q     <= count_d;
      locked_q    <= locked_d;
      prev_btn_q  <= prev_btn_d;
      blink_q     <= blink_d;
      blink_cnt_q <= blink_cnt_d;
      err_q       <= err_d;
    end
  end

  // response for the request being applied
  always_comb begin
    rsp_o              = '0;
    rsp_o.is_locked    = locked_d;
    rsp_o.error_light  = err_d;
    rsp_o.entry_result = result;
    rsp_o.digits_held  = kcl_pkg::HELD_W'(count_d);
  end

endmodule

// File: hdl/keypad_code_lock.sv
// Keypad code lock. A request is taken into an input register; once the output register is
// free the lock logic applies it in one pass and the response lands in an output register,
// so one request can be accepted every cycle while in_stall_o is low. in_stall_o rises
// only when the output register holds a response that the receiver is stalling and the
// input register is also full. The code digits are written through the cfg port and
// take effect for the next request.
//
// keypad_code_lock: top level with input and output registers around the lock core
// uses kcl_pkg, kcl_code_regs, kcl_lock_core
module keypad_code_lock #(
  parameter int CODE_LENGTH = kcl_pkg::CODE_LENGTH_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [kcl_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [kcl_pkg::DIGIT_W-1:0]   cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  kcl_pkg::in_req_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output kcl_pkg::out_rsp_t             out_rsp_o
);

  logic [CODE_LENGTH-1:0][kcl_pkg::DIGIT_W-1:0] code;
  logic                                         s1_valid_q;
  kcl_pkg::in_req_t                             s1_q;
  logic                                         out_valid_q;
  kcl_pkg::out_rsp_t                            out_q;
  kcl_pkg::out_rsp_t                            rsp;
  logic                                         out_free, fire, in_acc;

  kcl_code_regs #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_code_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cfg_we_i  (cfg_we_i),
    .cfg_idx_i (cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .code_o    (code)
  );

  kcl_lock_core #(
    .CODE_LENGTH(CODE_LENGTH)
  ) u_lock_core (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .fire_i(fire),
    .req_i (s1_q),
    .code_i(code),
    .rsp_o (rsp)
  );

  // handshake control
  assign out_free   = !out_valid_q || !out_stall_i;
  assign fire       = s1_valid_q && out_free;
  assign in_stall_o = s1_valid_q && !out_free;
  assign in_acc     = in_valid_i && !in_stall_o;

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_acc) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_q <= in_req_i;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_q <= rsp;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // checks
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s1_valid_q)
    else $error("input stalled with an empty input register");

  a_fire_fills_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("applied request did not reach the output register");

  a_accept_unlocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.entry_result == kcl_pkg::RES_ACCEPT))
      |-> !out_rsp_o.is_locked)
    else $error("accepted code left the lock locked");

  a_decided_clears_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_rsp_o.entry_result != kcl_pkg::RES_NONE))
      |-> (out_rsp_o.digits_held == '0))
    else $error("digit count not cleared after a completed code");

endmodule
